@@ design/imm_pkg.sv @@
// Shared types and constants for the integer matrix multiply core.
`timescale 1ns / 1ps
`default_nettype none
package imm_pkg;

	localparam int OP_W       = 2;
	localparam int IDX_W      = 3;
	localparam int DIM_REG_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int PRODUCT_W  = 35;
	localparam int OUT_TDATA_W = ((2 * IDX_W + PRODUCT_W + 7) / 8) * 8;

	localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_EMIT
	} state_t;

	// Control tag that walks down the cell chain beside each A element
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tag_t;

endpackage
`default_nettype wire

@@ design/integer_matrix_multiply_core.sv @@
// Integer matrix multiply core: element stores, cell chain and output stage.
//
// Load A and B one element per request on the s_ group (tuser = operation:
// write A, write B, compute). A compute request
// produces rows_a * cols_b product entries on the m_ group in row-major
// order, m_tlast on the final one. Dimensions come from the cfg port
// (0 is taken as 1, above MAX_DIM as MAX_DIM) and are sampled at compute.
// Each product row reads a row of A (inner size n) from its RAM into the
// cell chain, lets the last element pass the store read and ripple through
// the p cells (p = columns of B), then emits the row. No new request is
// taken during a compute run; the next is taken while the final entry
// still sits in the output register. A stalled receiver holds the output
// register and pauses the run. Reset clears the control state and sets all
// dimensions to 8; the stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module integer_matrix_multiply_core #(
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16,
	localparam int IN_W = ((2 * imm_pkg::IDX_W + ELEMENT_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [imm_pkg::DIM_REG_W-1:0]     cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// row_index[2:0], col_index[5:3], element_value[ELEMENT_WIDTH+5:6]
	input  logic [IN_W-1:0]                   s_tdata,
	// operation[1:0]
	input  logic [imm_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_row[2:0], out_col[5:3], product_value[40:6]
	output logic [imm_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import imm_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int AW    = 2 * DIM_W;

	function automatic logic [DIM_W-1:0] last_of(input logic [DIM_REG_W-1:0] d);
		if (d == '0) begin
			return '0;
		end else if (5'(d) >= 5'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM - 1);
		end else begin
			return DIM_W'(d - 4'd1);
		end
	endfunction

	state_t state_q, state_d;

	logic [DIM_REG_W-1:0] rows_a_q, inner_size_q, cols_b_q;
	logic [DIM_W-1:0]     m_last_q, n_last_q, p_last_q;
	logic [DIM_W-1:0]     i_q, k_q, j_q;

	op_t                      in_op;
	logic [IDX_W-1:0]         in_row, in_col;
	logic [ELEMENT_WIDTH-1:0] in_elem;
	logic                     in_acc, wr_ok, a_we, b_we;
	logic [DIM_W-1:0]         wr_row, wr_col;

	logic                     ram_re;
	logic [ELEMENT_WIDTH-1:0] ram_rdata;
	tag_t                     issue_tag, tag_s1;
	logic [DIM_W-1:0]         k_s1;

	logic signed [ELEMENT_WIDTH-1:0] chain_a   [MAX_DIM];
	logic [DIM_W-1:0]                chain_k   [MAX_DIM];
	tag_t                            chain_tag [MAX_DIM];
	logic signed [PRODUCT_W-1:0]     cell_acc  [MAX_DIM];
	logic [MAX_DIM-1:0]              cell_done;

	logic                 out_load, row_end;
	logic                 m_tvalid_q, m_tlast_q;
	logic [IDX_W-1:0]     out_row_q, out_col_q;
	logic [PRODUCT_W-1:0] product_q;

	assign in_op   = op_t'(s_tuser);
	assign in_row  = s_tdata[2:0];
	assign in_col  = s_tdata[5:3];
	assign in_elem = s_tdata[6 +: ELEMENT_WIDTH];
	assign in_acc  = s_tvalid && s_tready;
	assign wr_ok   = (5'(in_row) < 5'(MAX_DIM)) && (5'(in_col) < 5'(MAX_DIM));
	assign wr_row  = DIM_W'(in_row);
	assign wr_col  = DIM_W'(in_col);
	assign a_we    = in_acc && (in_op == OP_WRITE_A) && wr_ok;
	assign b_we    = in_acc && (in_op == OP_WRITE_B) && wr_ok;
	assign row_end = (j_q == p_last_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= DIM_RESET;
			inner_size_q <= DIM_RESET;
			cols_b_q     <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS_A:     rows_a_q     <= cfg_data;
				CFG_INNER_SIZE: inner_size_q <= cfg_data;
				CFG_COLS_B:     cols_b_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_op == OP_COMPUTE) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (k_q == n_last_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (cell_done[p_last_q]) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_load && row_end) begin
					state_d = (i_q == m_last_q) ? S_IDLE : S_ISSUE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready        = 1'b0;
		ram_re          = 1'b0;
		out_load        = 1'b0;
		issue_tag       = '0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_ISSUE: begin
				ram_re          = 1'b1;
				issue_tag.valid = 1'b1;
				issue_tag.first = (k_q == '0);
				issue_tag.last  = (k_q == n_last_q);
			end
			S_EMIT:  out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tag_s1     <= '0;
			m_tvalid_q <= 1'b0;
			m_last_q   <= '0;
			n_last_q   <= '0;
			p_last_q   <= '0;
			i_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
		end else begin
			state_q <= state_d;
			tag_s1  <= issue_tag;
			if (in_acc && in_op == OP_COMPUTE) begin
				m_last_q <= last_of(rows_a_q);
				n_last_q <= last_of(inner_size_q);
				p_last_q <= last_of(cols_b_q);
				i_q      <= '0;
				k_q      <= '0;
				j_q      <= '0;
			end
			if (state_q == S_ISSUE) begin
				k_q <= (k_q == n_last_q) ? '0 : k_q + 1'b1;
			end
			if (out_load) begin
				j_q <= row_end ? '0 : j_q + 1'b1;
				if (row_end) begin
					i_q <= i_q + 1'b1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (out_load) begin
			out_row_q <= IDX_W'(i_q);
			out_col_q <= IDX_W'(j_q);
			product_q <= cell_acc[j_q];
			m_tlast_q <= row_end && (i_q == m_last_q);
		end
	end

	imm_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (2 ** AW)
	) u_store_a (
		.clk   (clk),
		.we    (a_we),
		.waddr ({wr_row, wr_col}),
		.wdata (in_elem),
		.re    (ram_re),
		.raddr ({i_q, k_q}),
		.rdata (ram_rdata)
	);

	assign chain_a[0]   = $signed(ram_rdata);
	assign chain_k[0]   = k_s1;
	assign chain_tag[0] = tag_s1;

	// cell c holds column c of B and accumulates C[i][c]
	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		if (c < MAX_DIM - 1) begin : g_mid
			imm_cell #(
				.IDX           (c),
				.MAX_DIM       (MAX_DIM),
				.ELEMENT_WIDTH (ELEMENT_WIDTH)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.bw_en   (b_we),
				.bw_row  (wr_row),
				.bw_col  (wr_col),
				.bw_data ($signed(in_elem)),
				.a_in    (chain_a[c]),
				.k_in    (chain_k[c]),
				.tag_in  (chain_tag[c]),
				.a_out   (chain_a[c+1]),
				.k_out   (chain_k[c+1]),
				.tag_out (chain_tag[c+1]),
				.acc     (cell_acc[c]),
				.done    (cell_done[c])
			);
		end else begin : g_end
			imm_cell #(
				.IDX           (c),
				.MAX_DIM       (MAX_DIM),
				.ELEMENT_WIDTH (ELEMENT_WIDTH)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.bw_en   (b_we),
				.bw_row  (wr_row),
				.bw_col  (wr_col),
				.bw_data ($signed(in_elem)),
				.a_in    (chain_a[c]),
				.k_in    (chain_k[c]),
				.tag_in  (chain_tag[c]),
				.a_out   (),
				.k_out   (),
				.tag_out (),
				.acc     (cell_acc[c]),
				.done    (cell_done[c])
			);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{(OUT_TDATA_W - 2 * IDX_W - PRODUCT_W){1'b0}},
		product_q, out_col_q, out_row_q};

	// the final entry of a run returns the block to idle
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && row_end && (i_q == m_last_q) |=> state_q == S_IDLE)
		else $error("run did not end after final entry");

	// an A element enters the chain only from a read issued the cycle before
	a_tag_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> $past(state_q) == S_ISSUE)
		else $error("chain entry without a store read");

	// all reads of a row are in the chain before its results go out
	a_no_read_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !tag_s1.valid && !ram_re)
		else $error("store read during emit");

endmodule
`default_nettype wire

@@ design/imm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ design/imm_cell.sv @@
// One multiply-accumulate cell: holds a column of B, passes A elements on.
`timescale 1ns / 1ps
`default_nettype none
module imm_cell #(
	parameter int IDX           = 0,
	parameter int MAX_DIM       = 8,
	parameter int ELEMENT_WIDTH = 16,
	localparam int DIM_W = $clog2(MAX_DIM)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 bw_en,
	input  logic [DIM_W-1:0]                     bw_row,
	input  logic [DIM_W-1:0]                     bw_col,
	input  logic signed [ELEMENT_WIDTH-1:0]      bw_data,
	input  logic signed [ELEMENT_WIDTH-1:0]      a_in,
	input  logic [DIM_W-1:0]                     k_in,
	input  imm_pkg::tag_t                        tag_in,
	output logic signed [ELEMENT_WIDTH-1:0]      a_out,
	output logic [DIM_W-1:0]                     k_out,
	output imm_pkg::tag_t                        tag_out,
	output logic signed [imm_pkg::PRODUCT_W-1:0] acc,
	output logic                                 done
);
	import imm_pkg::*;

	logic signed [ELEMENT_WIDTH-1:0]   b_col_q [MAX_DIM];
	logic signed [ELEMENT_WIDTH-1:0]   a_q;
	logic [DIM_W-1:0]                  k_q;
	tag_t                              tag_q;
	logic signed [2*ELEMENT_WIDTH-1:0] prod_full;
	logic signed [PRODUCT_W-1:0]       prod_s1;
	logic signed [PRODUCT_W-1:0]       acc_q;
	logic                              done_q;

	assign prod_full = a_in * b_col_q[k_in];

	always_ff @(posedge clk) begin
		if (bw_en && bw_col == DIM_W'(IDX)) begin
			b_col_q[bw_row] <= bw_data;
		end
		a_q     <= a_in;
		k_q     <= k_in;
		// sums wrap at the product width, same low bits as a wider sum
		prod_s1 <= PRODUCT_W'(prod_full);
		if (tag_q.valid) begin
			acc_q <= tag_q.first ? prod_s1 : acc_q + prod_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q  <= '0;
			done_q <= 1'b0;
		end else begin
			tag_q  <= tag_in;
			done_q <= tag_q.valid && tag_q.last;
		end
	end

	assign a_out   = a_q;
	assign k_out   = k_q;
	assign tag_out = tag_q;
	assign acc     = acc_q;
	assign done    = done_q;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the integer matrix multiply core: directed table, then random phases.
`timescale 1ns / 1ps
module testbench;
	import imm_pkg::*;

	localparam int ELEMENT_W    = 16;
	localparam int S_TDATA_W    = ((2 * IDX_W + ELEMENT_W + 7) / 8) * 8;
	localparam int STORE_SIDE   = 8;
	localparam int RANDOM_ITEMS = 150;
	localparam int LONG_HOLD    = 400;
	localparam int IDLE_MARGIN  = 8;
	localparam int TAIL_CYCLES  = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     col;
		logic [PRODUCT_W-1:0] value;
		logic                 last;
	} product_entry_t;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     col;
		logic [ELEMENT_W-1:0] value;
	} request_t;

	typedef enum logic {
		ROW_REQUEST,
		ROW_CONFIG
	} row_kind_t;

	// typed = 1: product value is given in the row (single-entry product)
	typedef struct packed {
		row_kind_t            kind;
		request_t             req;
		logic                 typed;
		logic [PRODUCT_W-1:0] product;
		logic [DIM_REG_W-1:0] dim_rows;
		logic [DIM_REG_W-1:0] dim_inner;
		logic [DIM_REG_W-1:0] dim_cols;
	} directed_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DIM_REG_W-1:0]   cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	// row_index[2:0], col_index[5:3], element_value[21:6], zero fill above
	logic [S_TDATA_W-1:0]   s_tdata;
	// operation[1:0]
	logic [OP_W-1:0]        s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// out_row[2:0], out_col[5:3], product_value[40:6]
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	logic signed [ELEMENT_W-1:0] model_a [STORE_SIDE*STORE_SIDE];
	logic signed [ELEMENT_W-1:0] model_b [STORE_SIDE*STORE_SIDE];
	bit                          written_a [STORE_SIDE*STORE_SIDE];
	bit                          written_b [STORE_SIDE*STORE_SIDE];
	logic [DIM_REG_W-1:0]        dim_reg [3];
	product_entry_t              expected_products [$];
	request_t                    pending_requests [$];
	int                          error_count;
	int                          useful_items;
	bit                          long_hold_pending;
	bit                          sender_calm;

	directed_row_t directed_table [24] = '{
		'{ROW_CONFIG,  '{OP_WRITE_A, 3'd0, 3'd0, 16'h0000}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_A, 3'd0, 3'd0, 16'h8000}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd0, 16'h8000}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_COMPUTE, 3'd0, 3'd0, 16'h0000}, 1'b1, 35'd1073741824,
			4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_A, 3'd0, 3'd0, 16'h7FFF}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_COMPUTE, 3'd0, 3'd0, 16'h0000}, 1'b1, -35'sd1073709056,
			4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd0, 16'h7FFF}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_COMPUTE, 3'd0, 3'd0, 16'h0000}, 1'b1, 35'd1073676289,
			4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_UNDEFINED, 3'd7, 3'd7, 16'hAAAA}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_COMPUTE, 3'd0, 3'd0, 16'h0000}, 1'b1, 35'd1073676289,
			4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_A, 3'd0, 3'd0, 16'h0000}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_COMPUTE, 3'd0, 3'd0, 16'h0000}, 1'b1, 35'd0, 4'd0, 4'd0, 4'd0},
		// stored although outside the current dimensions
		'{ROW_REQUEST, '{OP_WRITE_A, 3'd7, 3'd7, 16'hFFFF}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd7, 3'd7, 16'h5555}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		// columns above the maximum are taken as the maximum
		'{ROW_CONFIG,  '{OP_WRITE_A, 3'd0, 3'd0, 16'h0000}, 1'b0, 35'd0, 4'd1, 4'd1, 4'd15},
		'{ROW_REQUEST, '{OP_WRITE_A, 3'd0, 3'd0, 16'hFFFF}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd1, 16'h7FFF}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd2, 16'h8000}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd3, 16'hFFFF}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd4, 16'h0001}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd5, 16'h3039}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd6, 16'hCFC7}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_WRITE_B, 3'd0, 3'd7, 16'h0000}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0},
		'{ROW_REQUEST, '{OP_COMPUTE, 3'd5, 3'd2, 16'h1234}, 1'b0, 35'd0, 4'd0, 4'd0, 4'd0}
	};

	integer_matrix_multiply_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	function automatic int effective_dim(input logic [DIM_REG_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > STORE_SIDE)
			return STORE_SIDE;
		return int'(d);
	endfunction

	function automatic int idle_length(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ELEMENT_W-1:0] pick_element();
		case ($urandom_range(0, 7))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'hFFFF;
		3: return 16'h0000;
		default: return ELEMENT_W'($urandom);
		endcase
	endfunction

	function automatic request_t make_request(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
			input logic [ELEMENT_W-1:0] value);
		request_t req;
		req.op    = op;
		req.row   = row;
		req.col   = col;
		req.value = value;
		return req;
	endfunction

	// Updates the stores and queues the product entries of an accepted request
	function automatic void apply_request(input request_t req, input logic typed,
			input logic [PRODUCT_W-1:0] typed_product);
		int m, n, p, idx;
		longint acc, a, b;
		product_entry_t entry;
		idx = int'(req.row) * STORE_SIDE + int'(req.col);
		case (req.op)
		OP_WRITE_A: begin
			model_a[idx]   = req.value;
			written_a[idx] = 1'b1;
		end
		OP_WRITE_B: begin
			model_b[idx]   = req.value;
			written_b[idx] = 1'b1;
		end
		OP_COMPUTE: begin
			m = effective_dim(dim_reg[CFG_ROWS_A]);
			n = effective_dim(dim_reg[CFG_INNER_SIZE]);
			p = effective_dim(dim_reg[CFG_COLS_B]);
			for (int i = 0; i < m; i++) begin
				for (int j = 0; j < p; j++) begin
					acc = 0;
					for (int k = 0; k < n; k++) begin
						a = model_a[i * STORE_SIDE + k];
						b = model_b[k * STORE_SIDE + j];
						acc += a * b;
					end
					entry.row   = IDX_W'(i);
					entry.col   = IDX_W'(j);
					entry.value = typed ? typed_product : acc[PRODUCT_W-1:0];
					entry.last  = (i == m - 1) && (j == p - 1);
					expected_products.push_back(entry);
				end
			end
		end
		default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic check_product();
		product_entry_t want;
		if (expected_products.size() == 0) begin
			report_mismatch("product entry with none expected", 64'(m_tdata), 64'd0);
		end else begin
			want = expected_products.pop_front();
			if (m_tdata[IDX_W-1:0] != want.row)
				report_mismatch("out_row", 64'(m_tdata[IDX_W-1:0]), 64'(want.row));
			if (m_tdata[IDX_W +: IDX_W] != want.col)
				report_mismatch("out_col", 64'(m_tdata[IDX_W +: IDX_W]), 64'(want.col));
			if (m_tdata[2*IDX_W +: PRODUCT_W] != want.value)
				report_mismatch("product_value", 64'(m_tdata[2*IDX_W +: PRODUCT_W]),
					64'(want.value));
			if (m_tlast != want.last)
				report_mismatch("last_entry", 64'(m_tlast), 64'(want.last));
		end
	endtask

	task automatic send_request(input request_t req, input logic typed,
			input logic [PRODUCT_W-1:0] typed_product);
		int gap;
		gap = sender_calm ? 0 : idle_length(55);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req.op;
		s_tdata  <= S_TDATA_W'({req.value, req.col, req.row});
		do @(posedge clk); while (!s_tready);
		apply_request(req, typed, typed_product);
	endtask

	task automatic send_pending();
		foreach (pending_requests[q]) begin
			send_request(pending_requests[q], 1'b0, '0);
			if (pending_requests[q].op != OP_UNDEFINED)
				useful_items++;
		end
		pending_requests.delete();
	endtask

	// Always waits on the clock before returning, so s_tvalid is never lowered and raised in one step
	task automatic wait_for_products(input int margin);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_products.size() != 0);
		repeat (margin) @(posedge clk);
	endtask

	task automatic set_dimensions(input logic [DIM_REG_W-1:0] rows,
			input logic [DIM_REG_W-1:0] inner, input logic [DIM_REG_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS_A;
		cfg_data  <= rows;
		@(posedge clk);
		dim_reg[CFG_ROWS_A] = rows;
		cfg_index <= CFG_INNER_SIZE;
		cfg_data  <= inner;
		@(posedge clk);
		dim_reg[CFG_INNER_SIZE] = inner;
		cfg_index <= CFG_COLS_B;
		cfg_data  <= cols;
		@(posedge clk);
		dim_reg[CFG_COLS_B] = cols;
		cfg_we <= 1'b0;
	endtask

	// Loads the operands (every entry the product reads is written), adds noise, computes;
	// sometimes rewrites a few entries and computes again
	task automatic run_phase(input logic [DIM_REG_W-1:0] rows,
			input logic [DIM_REG_W-1:0] inner, input logic [DIM_REG_W-1:0] cols,
			input bit hold_output);
		request_t swap;
		logic [OP_W-1:0] noise_op;
		int m, n, p, pick;
		wait_for_products(IDLE_MARGIN);
		set_dimensions(rows, inner, cols);
		sender_calm = ($urandom_range(0, 3) == 0);
		m = effective_dim(rows);
		n = effective_dim(inner);
		p = effective_dim(cols);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < n; k++)
				if (!written_a[i * STORE_SIDE + k] || $urandom_range(0, 1))
					pending_requests.push_back(make_request(OP_WRITE_A, IDX_W'(i),
						IDX_W'(k), pick_element()));
		for (int k = 0; k < n; k++)
			for (int j = 0; j < p; j++)
				if (!written_b[k * STORE_SIDE + j] || $urandom_range(0, 1))
					pending_requests.push_back(make_request(OP_WRITE_B, IDX_W'(k),
						IDX_W'(j), pick_element()));
		repeat ($urandom_range(0, 3)) begin
			noise_op = OP_W'($urandom_range(0, 3));
			if (noise_op == OP_COMPUTE)
				noise_op = OP_UNDEFINED;
			pending_requests.push_back(make_request(noise_op, IDX_W'($urandom),
				IDX_W'($urandom), ELEMENT_W'($urandom)));
		end
		for (int s = pending_requests.size() - 1; s > 0; s--) begin
			pick = $urandom_range(0, s);
			swap = pending_requests[s];
			pending_requests[s] = pending_requests[pick];
			pending_requests[pick] = swap;
		end
		pending_requests.push_back(make_request(OP_COMPUTE, IDX_W'($urandom),
			IDX_W'($urandom), ELEMENT_W'($urandom)));
		// output held back while further requests queue up behind the compute run
		if (hold_output)
			long_hold_pending = 1'b1;
		send_pending();
		if (hold_output || $urandom_range(0, 1)) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 1))
					pending_requests.push_back(make_request(OP_WRITE_A,
						IDX_W'($urandom_range(0, m - 1)), IDX_W'($urandom_range(0, n - 1)),
						pick_element()));
				else
					pending_requests.push_back(make_request(OP_WRITE_B,
						IDX_W'($urandom_range(0, n - 1)), IDX_W'($urandom_range(0, p - 1)),
						pick_element()));
			end
			pending_requests.push_back(make_request(OP_COMPUTE, IDX_W'($urandom),
				IDX_W'($urandom), ELEMENT_W'($urandom)));
			if (!hold_output && $urandom_range(0, 2) == 0)
				wait_for_products(0);
			send_pending();
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Receiver: checks each accepted entry, then picks m_tready for the next cycle
	initial begin
		int stall_left;
		bit calm;
		stall_left = 0;
		calm = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_product();
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0) begin
				stall_left = calm ? 0 : idle_length(80);
			end
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [DIM_REG_W-1:0] dims [3];
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		error_count       = 0;
		useful_items      = 0;
		long_hold_pending = 1'b0;
		sender_calm       = 1'b0;
		for (int d = 0; d < 3; d++)
			dim_reg[d] = DIM_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (directed_table[r]) begin
			if (directed_table[r].kind == ROW_CONFIG) begin
				wait_for_products(IDLE_MARGIN);
				set_dimensions(directed_table[r].dim_rows, directed_table[r].dim_inner,
					directed_table[r].dim_cols);
			end else begin
				send_request(directed_table[r].req, directed_table[r].typed,
					directed_table[r].product);
			end
		end

		// largest dimensions first, then mostly small random shapes
		run_phase(4'd8, 4'd1, 4'd8, 1'b1);
		run_phase(4'd15, 4'd1, 4'd15, 1'b0);
		run_phase(4'd1, 4'd8, 4'd1, 1'b0);
		run_phase(4'd1, 4'd15, 4'd1, 1'b0);
		while (useful_items < RANDOM_ITEMS) begin
			for (int d = 0; d < 3; d++)
				dims[d] = DIM_REG_W'($urandom_range(1, 4));
			if ($urandom_range(0, 5) == 0)
				dims[$urandom_range(0, 2)] = DIM_REG_W'($urandom_range(0, 15));
			run_phase(dims[0], dims[1], dims[2], 1'b0);
		end

		wait_for_products(TAIL_CYCLES);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
